// File: rtl/ibfb_pkg.sv
// Package for the interleaved Bloom filter bank.
// Holds hash constants, request kind codes, register indexes and shared types.
// No dependencies.
package ibfb_pkg;

  // MurmurHash3 x64_128 body and finaliser multipliers
  localparam logic [63:0] MM_C1   = 64'h87c37b91114253d5;
  localparam logic [63:0] MM_C2   = 64'h4cf5ad432745937f;
  localparam logic [63:0] FMIX_M1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FMIX_M2 = 64'hc4ceb9fe1a85ec53;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_INSERT = 2'd0;
  localparam kind_t KIND_QUERY  = 2'd1;
  localparam kind_t KIND_REJECT = 2'd2;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_FILTER_COUNT    = 2'd0;
  localparam reg_idx_t REG_BITS_PER_FILTER = 2'd1;
  localparam reg_idx_t REG_PROBE_COUNT     = 2'd2;

  // Status from the back end to the top level
  typedef struct packed {
    logic clearing;
    logic busy;
  } back_stat_t;

endpackage

// File: rtl/interleaved_bloom_filter_bank.sv
// Top level of the interleaved Bloom filter bank.
// Instantiates ibfb_front, ibfb_fifo and ibfb_back; uses ibfb_pkg.
//
// A bank of up to 64 Bloom filters sharing one MurmurHash3 x64_128 probe
// computation. After reset the block clears its bit matrix and item counts in
// a pass over all MAX_BITS rows (16384 by default) with in_full held high;
// config writes are taken during it. Each request is an insert into one
// filter or a query over all filters. The front end takes one request at a
// time: six 64-bit multiplies, each from three partial products on one
// shared 32x32 multiplier, two final adds, sixteen remainder steps and a
// queue push. The back end reads and then updates or checks the single-port
// bit matrix per probe, so for up to five probes the front end sets the rate.
// Requests queue between the two sides, and the result register lets a new
// request be accepted while an earlier result waits to be popped. Write the
// config registers only while the block is idle.
module interleaved_bloom_filter_bank #(
  parameter int MAX_FILTERS = 64,
  parameter int MAX_BITS    = 16384,
  parameter int MAX_PROBES  = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_func,
  input  logic [5:0]  in_filter_index,
  input  logic [63:0] in_key_bits,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [63:0] out_presence,
  output logic [31:0] out_item_count,
  output logic        out_index_error,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_data
);

  localparam int AW = $clog2(MAX_BITS);
  localparam int QW = 2 + 6 + 2*AW;

  // Config registers
  logic [6:0]  fc_r, fc_nxt;
  logic [14:0] bpf_r, bpf_nxt;
  logic [2:0]  pc_r, pc_nxt;

  // Effective (clamped) config
  logic [6:0]  nf;
  logic [AW:0] m;
  logic [2:0]  k;

  logic                 fe_busy, acc;
  logic                 q_wr, q_full, q_pop, q_empty;
  logic [QW-1:0]        q_din, q_dout;
  ibfb_pkg::back_stat_t bstat;

  // Hold off requests during the clearing pass and while hashing
  assign in_full = fe_busy || bstat.clearing;
  assign acc     = in_push && !in_full;

  always_comb begin
    fc_nxt  = fc_r;
    bpf_nxt = bpf_r;
    pc_nxt  = pc_r;
    if (cfg_we) begin
      unique case (cfg_index)
        ibfb_pkg::REG_FILTER_COUNT:    fc_nxt  = cfg_data[6:0];
        ibfb_pkg::REG_BITS_PER_FILTER: bpf_nxt = cfg_data;
        ibfb_pkg::REG_PROBE_COUNT:     pc_nxt  = cfg_data[2:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r  <= 7'd64;
      bpf_r <= 15'd16384;
      pc_r  <= 3'd3;
    end else begin
      fc_r  <= fc_nxt;
      bpf_r <= bpf_nxt;
      pc_r  <= pc_nxt;
    end
  end

  // Clamp to the ranges the storage supports
  always_comb begin
    nf = (32'(fc_r) > MAX_FILTERS) ? 7'(MAX_FILTERS) : fc_r;
    if (bpf_r == '0) begin
      m = (AW+1)'(1);
    end else if (32'(bpf_r) > MAX_BITS) begin
      m = (AW+1)'(MAX_BITS);
    end else begin
      m = (AW+1)'(bpf_r);
    end
    if (pc_r == '0) begin
      k = 3'd1;
    end else if (32'(pc_r) > MAX_PROBES) begin
      k = 3'(MAX_PROBES);
    end else begin
      k = pc_r;
    end
  end

  ibfb_front #(.AW(AW)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .acc    (acc),
    .func   (in_func),
    .fidx   (in_filter_index),
    .key    (in_key_bits),
    .nf     (nf),
    .m      (m),
    .busy   (fe_busy),
    .q_wr   (q_wr),
    .q_data (q_din),
    .q_full (q_full)
  );

  ibfb_fifo #(.WIDTH(QW), .DEPTH(2)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .din   (q_din),
    .full  (q_full),
    .rd    (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  ibfb_back #(
    .AW          (AW),
    .MAX_FILTERS (MAX_FILTERS),
    .MAX_BITS    (MAX_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_data          (q_dout),
    .q_pop           (q_pop),
    .nf              (nf),
    .m               (m),
    .k               (k),
    .stat            (bstat),
    .res_empty       (out_empty),
    .res_pop         (out_pop),
    .res_presence    (out_presence),
    .res_item_count  (out_item_count),
    .res_index_error (out_index_error)
  );

endmodule

// File: rtl/ibfb_fifo.sv
// Small request queue between the hash front end and the probe back end.
// Generic width and depth; no package dependency.
module ibfb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wp_r, wp_nxt;
  logic [PW-1:0]    rp_r, rp_nxt;
  logic [PW:0]      cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full  = (cnt_r == (PW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rp_r];
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_rd) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule

// File: rtl/ibfb_front.sv
// Front end: accepts a request, classifies it, hashes the key and reduces the
// two hashes modulo the bit count. Uses ibfb_pkg; feeds ibfb_fifo.
module ibfb_front #(
  parameter int AW = 14
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  acc,
  input  logic                  func,
  input  logic [5:0]            fidx,
  input  logic [63:0]           key,
  input  logic [6:0]            nf,
  input  logic [AW:0]           m,
  output logic                  busy,
  output logic                  q_wr,
  output logic [2+6+2*AW-1:0]   q_data,
  input  logic                  q_full
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_FIN1 = 3'd2;
  localparam logic [2:0] S_FIN2 = 3'd3;
  localparam logic [2:0] S_MOD  = 3'd4;
  localparam logic [2:0] S_PUSH = 3'd5;

  logic [2:0]           st_r, st_nxt;
  ibfb_pkg::kind_t      kind_r, kind_nxt;
  logic [5:0]           fidx_r, fidx_nxt;
  logic [63:0]          a_r, a_nxt, b_r, b_nxt;
  logic [63:0]          prod_r, prod_nxt, acc_r, acc_nxt;
  logic [2:0]           ms_r, ms_nxt;
  logic [2:0]           ph_r, ph_nxt;
  logic [3:0]           cnt_r, cnt_nxt;
  logic [AW-1:0]        ra_r, ra_nxt, rb_r, rb_nxt;

  logic [63:0] x_op, c_op, a1, b1;
  logic [31:0] mul_a, mul_b;
  logic [AW:0] ta, tb;

  assign busy   = (st_r != S_IDLE);
  assign q_wr   = (st_r == S_PUSH);
  assign q_data = {kind_r, fidx_r, ra_r, rb_r};

  always_comb begin
    x_op = (ms_r < 3'd4) ? a_r : b_r;
    unique case (ms_r)
      3'd0:    c_op = ibfb_pkg::MM_C1;
      3'd1:    c_op = ibfb_pkg::MM_C2;
      3'd2,
      3'd4:    c_op = ibfb_pkg::FMIX_M1;
      default: c_op = ibfb_pkg::FMIX_M2;
    endcase
    case (ph_r)
      3'd0:    begin mul_a = x_op[31:0];  mul_b = c_op[31:0];  end
      3'd1:    begin mul_a = x_op[31:0];  mul_b = c_op[63:32]; end
      default: begin mul_a = x_op[63:32]; mul_b = c_op[31:0];  end
    endcase
    prod_nxt = 64'(mul_a) * 64'(mul_b);
  end

  always_comb begin
    st_nxt   = st_r;
    kind_nxt = kind_r;
    fidx_nxt = fidx_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    ms_nxt   = ms_r;
    ph_nxt   = ph_r;
    cnt_nxt  = cnt_r;
    ra_nxt   = ra_r;
    rb_nxt   = rb_r;
    a1       = (acc_r ^ 64'd8) + 64'd8;
    b1       = a1 + 64'd8;
    ta       = '0;
    tb       = '0;
    unique case (st_r)
      S_IDLE: begin
        if (acc) begin
          fidx_nxt = fidx;
          a_nxt    = key;
          ms_nxt   = '0;
          ph_nxt   = '0;
          ra_nxt   = '0;
          rb_nxt   = '0;
          if (func) begin
            kind_nxt = ibfb_pkg::KIND_QUERY;
            st_nxt   = S_MUL;
          end else if ({1'b0, fidx} >= nf) begin
            kind_nxt = ibfb_pkg::KIND_REJECT;
            st_nxt   = S_PUSH;
          end else begin
            kind_nxt = ibfb_pkg::KIND_INSERT;
            st_nxt   = S_MUL;
          end
        end
      end
      S_MUL: begin
        // three 32x32 partial products give the low 64 bits of the product
        case (ph_r)
          3'd1:    acc_nxt = prod_r;
          3'd2,
          3'd3:    acc_nxt = acc_r + {prod_r[31:0], 32'd0};
          default: acc_nxt = acc_r;
        endcase
        ph_nxt = ph_r + 1'b1;
        if (ph_r == 3'd4) begin
          ph_nxt = '0;
          ms_nxt = ms_r + 1'b1;
          case (ms_r)
            3'd0:    a_nxt = {acc_r[32:0], acc_r[63:33]};
            3'd1: begin
              a_nxt = a1 ^ (a1 >> 33);
              b_nxt = b1 ^ (b1 >> 33);
            end
            3'd2,
            3'd3:    a_nxt = acc_r ^ (acc_r >> 33);
            default: b_nxt = acc_r ^ (acc_r >> 33);
          endcase
          if (ms_r == 3'd5) begin
            st_nxt = S_FIN1;
          end
        end
      end
      S_FIN1: begin
        a_nxt  = a_r + b_r;
        st_nxt = S_FIN2;
      end
      S_FIN2: begin
        b_nxt   = b_r + a_r;
        cnt_nxt = '0;
        st_nxt  = S_MOD;
      end
      S_MOD: begin
        // four remainder bits a cycle, most significant first
        ta = {1'b0, ra_r};
        tb = {1'b0, rb_r};
        for (int j = 0; j < 4; j++) begin
          ta = {ta[AW-1:0], a_r[63-j]};
          if (ta >= m) ta = ta - m;
          tb = {tb[AW-1:0], b_r[63-j]};
          if (tb >= m) tb = tb - m;
        end
        ra_nxt  = ta[AW-1:0];
        rb_nxt  = tb[AW-1:0];
        a_nxt   = {a_r[59:0], 4'd0};
        b_nxt   = {b_r[59:0], 4'd0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 4'd15) begin
          st_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (!q_full) begin
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    fidx_r <= fidx_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    ms_r   <= ms_nxt;
    ph_r   <= ph_nxt;
    cnt_r  <= cnt_nxt;
    ra_r   <= ra_nxt;
    rb_r   <= rb_nxt;
  end

endmodule

// File: rtl/ibfb_back.sv
// Back end: walks the probe positions of one queued request over the bit
// matrix, keeps the per-filter item counts and holds the result. Uses ibfb_pkg.
module ibfb_back #(
  parameter int AW = 14,
  parameter int MAX_FILTERS = 64,
  parameter int MAX_BITS = 16384
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  logic [2+6+2*AW-1:0]  q_data,
  output logic                 q_pop,
  input  logic [6:0]           nf,
  input  logic [AW:0]          m,
  input  logic [2:0]           k,
  output ibfb_pkg::back_stat_t stat,
  output logic                 res_empty,
  input  logic                 res_pop,
  output logic [63:0]          res_presence,
  output logic [31:0]          res_item_count,
  output logic                 res_index_error
);

  localparam int MF = MAX_FILTERS;
  localparam int FW = (MF > 1) ? $clog2(MF) : 1;

  localparam logic [2:0] B_CLR  = 3'd0;
  localparam logic [2:0] B_IDLE = 3'd1;
  localparam logic [2:0] B_RD   = 3'd2;
  localparam logic [2:0] B_USE  = 3'd3;
  localparam logic [2:0] B_CNT  = 3'd4;
  localparam logic [2:0] B_OUT  = 3'd5;

  logic [MF-1:0] bits_mem [MAX_BITS];
  logic [31:0]   cnt_mem  [MF];

  logic [2:0]      st_r, st_nxt;
  logic [AW-1:0]   clr_r, clr_nxt;
  ibfb_pkg::kind_t kind_r, kind_nxt;
  logic [5:0]      fidx_r, fidx_nxt;
  logic [AW-1:0]   pos_r, pos_nxt, step_r, step_nxt;
  logic [2:0]      i_r, i_nxt;
  logic [MF-1:0]   vec_r, vec_nxt;
  logic [MF-1:0]   rd_r;
  logic [31:0]     crd_r;
  logic [63:0]     pp_r, pp_nxt;
  logic [31:0]     pc_r, pc_nxt;
  logic            pe_r, pe_nxt;
  logic            rv_r, rv_nxt;
  logic [63:0]     rp_r;
  logic [31:0]     rc_r;
  logic            re_r;

  logic            m_we, c_we, load;
  logic [AW-1:0]   m_wa;
  logic [MF-1:0]   m_wd;
  logic [FW-1:0]   c_wa;
  logic [31:0]     c_wd;
  logic [AW:0]     psum;
  logic [MF:0]     mask;

  ibfb_pkg::kind_t q_kind;
  logic [5:0]      q_fidx;
  logic [AW-1:0]   q_base, q_step;

  assign {q_kind, q_fidx, q_base, q_step} = q_data;
  assign stat.clearing  = (st_r == B_CLR);
  assign stat.busy      = (st_r != B_IDLE) || !q_empty;
  assign q_pop          = (st_r == B_IDLE) && !q_empty;
  assign res_empty      = !rv_r;
  assign res_presence   = rp_r;
  assign res_item_count = rc_r;
  assign res_index_error = re_r;
  assign mask           = ((MF+1)'(1) << nf) - 1'b1;
  assign psum           = {1'b0, pos_r} + {1'b0, step_r};
  assign load           = (st_r == B_OUT) && (!rv_r || res_pop);

  always_comb begin
    st_nxt   = st_r;
    clr_nxt  = clr_r;
    kind_nxt = kind_r;
    fidx_nxt = fidx_r;
    pos_nxt  = pos_r;
    step_nxt = step_r;
    i_nxt    = i_r;
    vec_nxt  = vec_r;
    pp_nxt   = pp_r;
    pc_nxt   = pc_r;
    pe_nxt   = pe_r;
    m_we     = 1'b0;
    m_wa     = pos_r;
    m_wd     = rd_r | (MF'(1'b1) << fidx_r[FW-1:0]);
    c_we     = 1'b0;
    c_wa     = fidx_r[FW-1:0];
    c_wd     = (crd_r == 32'hFFFF_FFFF) ? crd_r : crd_r + 1'b1;
    unique case (st_r)
      B_CLR: begin
        m_we    = 1'b1;
        m_wa    = clr_r;
        m_wd    = '0;
        c_we    = (32'(clr_r) < MF);
        c_wa    = clr_r[FW-1:0];
        c_wd    = '0;
        clr_nxt = clr_r + 1'b1;
        if (32'(clr_r) == MAX_BITS - 1) begin
          st_nxt = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!q_empty) begin
          kind_nxt = q_kind;
          fidx_nxt = q_fidx;
          pos_nxt  = q_base;
          step_nxt = q_step;
          i_nxt    = '0;
          vec_nxt  = mask[MF-1:0];
          pp_nxt   = '0;
          pc_nxt   = '0;
          pe_nxt   = (q_kind == ibfb_pkg::KIND_REJECT);
          st_nxt   = (q_kind == ibfb_pkg::KIND_REJECT) ? B_OUT : B_RD;
        end
      end
      B_RD: st_nxt = B_USE;
      B_USE: begin
        if (kind_r == ibfb_pkg::KIND_INSERT) begin
          m_we = 1'b1;
        end else begin
          vec_nxt = vec_r & rd_r;
        end
        pos_nxt = (psum >= m) ? AW'(psum - m) : psum[AW-1:0];
        i_nxt   = i_r + 1'b1;
        if (i_nxt == k) begin
          if (kind_r == ibfb_pkg::KIND_INSERT) begin
            st_nxt = B_CNT;
          end else begin
            pp_nxt = 64'(vec_r & rd_r);
            st_nxt = B_OUT;
          end
        end else begin
          st_nxt = B_RD;
        end
      end
      B_CNT: begin
        c_we   = 1'b1;
        pc_nxt = c_wd;
        st_nxt = B_OUT;
      end
      B_OUT: begin
        if (load) begin
          st_nxt = B_IDLE;
        end
      end
      default: st_nxt = B_IDLE;
    endcase
    rv_nxt = rv_r;
    if (load) begin
      rv_nxt = 1'b1;
    end else if (res_pop) begin
      rv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= B_CLR;
      clr_r <= '0;
      rv_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      clr_r <= clr_nxt;
      rv_r  <= rv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    fidx_r <= fidx_nxt;
    pos_r  <= pos_nxt;
    step_r <= step_nxt;
    i_r    <= i_nxt;
    vec_r  <= vec_nxt;
    pp_r   <= pp_nxt;
    pc_r   <= pc_nxt;
    pe_r   <= pe_nxt;
    if (load) begin
      rp_r <= pp_r;
      rc_r <= pc_r;
      re_r <= pe_r;
    end
  end

  always_ff @(posedge clk) begin
    if (m_we) begin
      bits_mem[m_wa] <= m_wd;
    end
    rd_r <= bits_mem[pos_r];
  end

  always_ff @(posedge clk) begin
    if (c_we) begin
      cnt_mem[c_wa] <= c_wd;
    end
    crd_r <= cnt_mem[fidx_r[FW-1:0]];
  end

endmodule

// File: dv/interleaved_bloom_filter_bank_tb.sv
// Self-checking testbench for the interleaved Bloom filter bank.
// Drives insert and query requests, predicts every result in place and checks it.
// Depends on ibfb_pkg and interleaved_bloom_filter_bank.
`timescale 1ns / 100ps

module interleaved_bloom_filter_bank_tb;

  localparam int BANK_FILTERS = 64;
  localparam int NUM_BITS     = 16384;
  localparam int NUM_PROBES   = 5;
  localparam int RANDOM_ITEMS = 1830;
  localparam int DRAIN_CYCLES = 400;
  localparam longint CYCLE_LIMIT = 2000000;

  localparam bit FUNC_INSERT = 1'b0;
  localparam bit FUNC_QUERY  = 1'b1;

  typedef struct packed {
    logic [63:0] presence;
    logic [31:0] item_count;
    logic        index_error;
  } bloom_result_t;

  // Directed stimulus: a request, and an expected result where it is obvious.
  typedef struct {
    bit            func;
    logic [5:0]    fidx;
    logic [63:0]   key;
    bit            typed;
    bloom_result_t want;
  } bloom_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic        in_func = 1'b0;
  logic [5:0]  in_filter_index = '0;
  logic [63:0] in_key_bits = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [63:0] out_presence;
  logic [31:0] out_item_count;
  logic        out_index_error;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [14:0] cfg_data = '0;

  interleaved_bloom_filter_bank dut (.*);

  // Shadow state of the bank
  logic [63:0] shadow_bits [NUM_BITS];
  logic [31:0] shadow_counts [BANK_FILTERS];
  logic [6:0]  sh_filter_count;
  logic [14:0] sh_bits_per_filter;
  logic [2:0]  sh_probe_count;

  bloom_result_t pending_results[$];
  int     fail_count = 0;
  longint cycle_count = 0;
  bit     long_hold = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: one global limit on the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("interleaved_bloom_filter_bank_tb failed");
      $finish;
    end
  end

  function automatic logic [63:0] fmix64(logic [63:0] v);
    v = v ^ (v >> 33);
    v = v * ibfb_pkg::FMIX_M1;
    v = v ^ (v >> 33);
    v = v * ibfb_pkg::FMIX_M2;
    v = v ^ (v >> 33);
    return v;
  endfunction

  // MurmurHash3 x64_128 over one 8-byte block, seed zero
  function automatic void murmur_key(input logic [63:0] key,
                                     output logic [63:0] ha, output logic [63:0] hb);
    logic [63:0] t;
    logic [63:0] a;
    logic [63:0] b;
    t = key * ibfb_pkg::MM_C1;
    t = {t[32:0], t[63:33]};
    t = t * ibfb_pkg::MM_C2;
    a = t ^ 64'd8;
    b = 64'd8;
    a = a + b;
    b = b + a;
    a = fmix64(a);
    b = fmix64(b);
    a = a + b;
    b = b + a;
    ha = a;
    hb = b;
  endfunction

  // Work out the result of one request and advance the shadow state
  function automatic bloom_result_t bank_apply(bit func, logic [5:0] fidx,
                                               logic [63:0] key);
    bloom_result_t r;
    logic [63:0] ha;
    logic [63:0] hb;
    longint unsigned nf;
    longint unsigned m;
    longint unsigned k;
    longint unsigned base;
    longint unsigned stp;
    longint unsigned pos;
    logic [63:0] vec;
    r = '0;
    nf = (sh_filter_count > BANK_FILTERS) ? BANK_FILTERS : sh_filter_count;
    m = (sh_bits_per_filter == 0) ? 1 :
        (sh_bits_per_filter > NUM_BITS) ? NUM_BITS : sh_bits_per_filter;
    k = (sh_probe_count == 0) ? 1 :
        (sh_probe_count > NUM_PROBES) ? NUM_PROBES : sh_probe_count;
    murmur_key(key, ha, hb);
    base = ha % m;
    stp = hb % m;
    if (func == FUNC_INSERT) begin
      if (fidx >= nf) begin
        r.index_error = 1'b1;
        return r;
      end
      for (longint unsigned i = 0; i < k; i++) begin
        pos = (base + i * stp) % m;
        shadow_bits[pos][fidx] = 1'b1;
      end
      if (shadow_counts[fidx] != 32'hFFFF_FFFF)
        shadow_counts[fidx] = shadow_counts[fidx] + 1;
      r.item_count = shadow_counts[fidx];
      return r;
    end
    if (nf == 0) return r;
    vec = (nf >= 64) ? '1 : ((64'd1 << nf) - 1);
    for (longint unsigned i = 0; i < k; i++) begin
      pos = (base + i * stp) % m;
      vec = vec & shadow_bits[pos];
    end
    r.presence = vec;
    return r;
  endfunction

  // Hand over one request; hold it until the bank takes it
  task automatic send_request(bit func, logic [5:0] fidx, logic [63:0] key,
                              bit typed, bloom_result_t want);
    bloom_result_t got;
    got = bank_apply(func, fidx, key);
    if (typed && got !== want) begin
      $error("typed row disagrees with prediction: %h vs %h", want, got);
      fail_count++;
    end
    in_func = func;
    in_filter_index = fidx;
    in_key_bits = key;
    in_push = 1'b1;
    do @(posedge clk); while (in_full);
    pending_results.push_back(got);
    @(negedge clk);
    in_push = 1'b0;
  endtask

  task automatic write_reg(ibfb_pkg::reg_idx_t idx, logic [14:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      ibfb_pkg::REG_FILTER_COUNT:    sh_filter_count = val[6:0];
      ibfb_pkg::REG_BITS_PER_FILTER: sh_bits_per_filter = val;
      ibfb_pkg::REG_PROBE_COUNT:     sh_probe_count = val[2:0];
      default: ;
    endcase
  endtask

  // Wait until every result is back, then let the back end settle
  task automatic drain_bank();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_config(logic [14:0] nf, logic [14:0] bits, logic [14:0] pr);
    drain_bank();
    write_reg(ibfb_pkg::REG_FILTER_COUNT, nf);
    write_reg(ibfb_pkg::REG_BITS_PER_FILTER, bits);
    write_reg(ibfb_pkg::REG_PROBE_COUNT, pr);
  endtask

  // Sender gap: mostly bursts, sometimes a pause
  task automatic sender_gap();
    if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 60)) @(negedge clk);
  endtask

  // Receiver: stalls on its own pattern, with one long hold-off
  initial begin
    int phase;
    phase = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      phase = phase + 1;
      if (long_hold) out_pop <= 1'b0;
      else if ((phase / 200) % 3 == 0) out_pop <= 1'b1;
      else out_pop <= ($urandom_range(0, 3) != 0);
    end
  end

  // Check each popped result against the oldest prediction
  always @(posedge clk) begin
    bloom_result_t exp_r;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected");
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_presence !== exp_r.presence) begin
          $error("presence: expected %h, got %h", exp_r.presence, out_presence);
          fail_count++;
        end
        if (out_item_count !== exp_r.item_count) begin
          $error("item_count: expected %h, got %h", exp_r.item_count, out_item_count);
          fail_count++;
        end
        if (out_index_error !== exp_r.index_error) begin
          $error("index_error: expected %b, got %b", exp_r.index_error, out_index_error);
          fail_count++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    bloom_row_t rows[$];
    bloom_row_t row;
    logic [63:0] recent_keys[$];
    logic [63:0] key;
    bit func;
    logic [5:0] fidx;
    int pick;

    for (int i = 0; i < NUM_BITS; i++) shadow_bits[i] = '0;
    for (int i = 0; i < BANK_FILTERS; i++) shadow_counts[i] = '0;
    sh_filter_count = 7'd64;
    sh_bits_per_filter = 15'd16384;
    sh_probe_count = 3'd3;

    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // Directed rows: empty bank, extremes of key and index, repeat hits
    rows.push_back('{FUNC_QUERY, 6'd0, 64'd0, 1'b1, '{64'd0, 32'd0, 1'b0}});
    rows.push_back('{FUNC_QUERY, 6'd63, '1, 1'b1, '{64'd0, 32'd0, 1'b0}});
    rows.push_back('{FUNC_INSERT, 6'd0, 64'd0, 1'b1, '{64'd0, 32'd1, 1'b0}});
    rows.push_back('{FUNC_INSERT, 6'd63, '1, 1'b1, '{64'd0, 32'd1, 1'b0}});
    rows.push_back('{FUNC_INSERT, 6'd63, 64'h8000_0000_0000_0001, 1'b1,
                     '{64'd0, 32'd2, 1'b0}});
    rows.push_back('{FUNC_QUERY, 6'd5, 64'd0, 1'b0, '0});
    rows.push_back('{FUNC_QUERY, 6'd0, '1, 1'b0, '0});
    rows.push_back('{FUNC_INSERT, 6'd31, 64'h0123_4567_89ab_cdef, 1'b0, '0});
    rows.push_back('{FUNC_QUERY, 6'd0, 64'h0123_4567_89ab_cdef, 1'b0, '0});
    rows.push_back('{FUNC_QUERY, 6'd0, 64'hdead_beef_0000_0001, 1'b0, '0});
    foreach (rows[i]) begin
      row = rows[i];
      send_request(row.func, row.fidx, row.key, row.typed, row.want);
    end

    // No filters in use: inserts rejected, queries empty
    set_config(15'd0, 15'd16384, 15'd3);
    send_request(FUNC_INSERT, 6'd0, 64'd7, 1'b1, '{64'd0, 32'd0, 1'b1});
    send_request(FUNC_QUERY, 6'd0, 64'd0, 1'b1, '{64'd0, 32'd0, 1'b0});
    // Filter count above the bank size, bit count zero, probe count zero
    set_config(15'd127, 15'd0, 15'd0);
    send_request(FUNC_INSERT, 6'd40, 64'd99, 1'b0, '0);
    send_request(FUNC_QUERY, 6'd0, 64'd12345, 1'b0, '0);
    // Bit count above the maximum, probe count above five
    set_config(15'd10, 15'h7FFF, 15'd7);
    send_request(FUNC_INSERT, 6'd10, 64'd3, 1'b1, '{64'd0, 32'd0, 1'b1});
    send_request(FUNC_INSERT, 6'd9, 64'd3, 1'b0, '0);
    send_request(FUNC_QUERY, 6'd0, 64'd3, 1'b0, '0);

    // Random phases over several settings, small bit counts to hit often
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_config(15'd64, 15'd16384, 15'd3);
        1: set_config(15'd64, 15'd1, 15'd1);
        2: set_config(15'd8, 15'd37, 15'd5);
        3: set_config(15'd64, 15'd200, 15'd2);
        4: set_config(15'($urandom_range(1, 64)), 15'($urandom_range(1, 600)),
                      15'($urandom_range(0, 7)));
        5: set_config(15'd33, 15'd1000, 15'd4);
        6: set_config(15'($urandom_range(0, 127)), 15'($urandom_range(0, 32767)),
                      15'($urandom_range(0, 7)));
        default: set_config(15'd64, 15'd64, 15'd5);
      endcase
      for (int n = 0; n < RANDOM_ITEMS / 8; n++) begin
        // Receiver holds off while the sender keeps offering requests
        if (ph == 3 && n == 10) begin
          fork
            begin
              long_hold = 1'b1;
              repeat (3000) @(negedge clk);
              long_hold = 1'b0;
            end
          join_none
        end
        // Sender pauses until every result has come back
        if (ph == 5 && n == 50)
          while (pending_results.size() != 0) @(negedge clk);
        pick = $urandom_range(0, 9);
        if (pick < 4 && recent_keys.size() != 0)
          key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
        else
          key = {$urandom, $urandom};
        func = ($urandom_range(0, 1) == 1) ? FUNC_QUERY : FUNC_INSERT;
        fidx = 6'($urandom_range(0, 63));
        if (func == FUNC_INSERT) begin
          recent_keys.push_back(key);
          if (recent_keys.size() > 40) void'(recent_keys.pop_front());
        end
        send_request(func, fidx, key, 1'b0, '0);
        sender_gap();
      end
    end

    // Saturation cannot be reached in this run; the counts only grow
    drain_bank();
    if (fail_count == 0) begin
      $display("interleaved_bloom_filter_bank_tb passed");
    end else begin
      $display("interleaved_bloom_filter_bank_tb failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/ibfb_pkg.sv
rtl/ibfb_fifo.sv
rtl/ibfb_front.sv
rtl/ibfb_back.sv
rtl/interleaved_bloom_filter_bank.sv
dv/interleaved_bloom_filter_bank_tb.sv
